@@ hw/rtl/gpio_function_select_set_clear_pull_defines.svh @@
// ----------------------------------------------------------------------------
// GPIO controller assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef GPIO_FUNCTION_SELECT_SET_CLEAR_PULL_DEFINES_SVH
`define GPIO_FUNCTION_SELECT_SET_CLEAR_PULL_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define GFSCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gpio_fscp: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define GFSCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gpio_fscp: next-cycle check failed");

`endif

@@ hw/rtl/gpio_fscp_pkg.sv @@
// ----------------------------------------------------------------------------
// gpio_fscp_pkg
// Register map, pull codes and bus access types of the GPIO controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gpio_fscp_pkg;

	// Register map (word addresses)
	localparam int unsigned FSEL_REGS = 6;
	localparam int unsigned FSEL_BITS = 30;
	localparam int unsigned PINS_PER_FSEL = 10;
	localparam int unsigned PIN_VEC_W = 64;

	localparam logic [5:0] ADDR_FSEL_LAST = 6'd5;
	localparam logic [5:0] ADDR_SET0      = 6'd7;
	localparam logic [5:0] ADDR_SET1      = 6'd8;
	localparam logic [5:0] ADDR_CLR0      = 6'd10;
	localparam logic [5:0] ADDR_CLR1      = 6'd11;
	localparam logic [5:0] ADDR_PUD       = 6'd37;
	localparam logic [5:0] ADDR_PUDCLK0   = 6'd38;
	localparam logic [5:0] ADDR_PUDCLK1   = 6'd39;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef enum logic [1:0] {
		PULL_OFF  = 2'd0,
		PULL_DOWN = 2'd1,
		PULL_UP   = 2'd2,
		PULL_RSVD = 2'd3
	} pull_code_t;

	// One bus access
	typedef struct packed {
		logic        wr;
		logic [5:0]  addr;
		logic [31:0] data;
	} req_t;

	// Per-access response apart from the pin vectors
	typedef struct packed {
		logic [31:0] rdata;
		logic        unmapped;
	} rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/gpio_fscp_regs.sv @@
// ----------------------------------------------------------------------------
// gpio_fscp_regs
// Register state of the GPIO controller and the next-state logic of one access.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_fscp_regs #(
	parameter int unsigned NUM_PINS = 54
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  acc_en,
	input  wire gpio_fscp_pkg::req_t   req,
	output gpio_fscp_pkg::rsp_t        rsp,
	output logic [NUM_PINS-1:0]        drive_nxt,
	output logic [NUM_PINS-1:0]        up_nxt,
	output logic [NUM_PINS-1:0]        down_nxt
);
	import gpio_fscp_pkg::*;

	typedef logic [FSEL_REGS-1:0][FSEL_BITS-1:0] fsel_mask_t;

	// Bits of each function-select word that name existing pins
	function automatic fsel_mask_t build_masks();
		fsel_mask_t m;
		m = '0;
		for (int r = 0; r < FSEL_REGS; r++) begin
			for (int p = 0; p < PINS_PER_FSEL; p++) begin
				for (int k = 0; k < 3; k++) begin
					m[r][3*p+k] = ((r * PINS_PER_FSEL + p) < NUM_PINS);
				end
			end
		end
		return m;
	endfunction

	localparam fsel_mask_t FSEL_MASK = build_masks();

	logic [FSEL_REGS-1:0][FSEL_BITS-1:0] fsel_q;
	logic [NUM_PINS-1:0]                 drive_q;
	logic [NUM_PINS-1:0]                 up_q;
	logic [NUM_PINS-1:0]                 down_q;
	pull_code_t                          pcode_q;

	logic [FSEL_REGS-1:0][FSEL_BITS-1:0] fsel_nxt;
	pull_code_t                          pcode_nxt;
	logic [PIN_VEC_W-1:0]                wide;
	logic [NUM_PINS-1:0]                 pins;
	logic                                hi_half;
	logic [2:0]                          fidx;

	// Place the 32-bit word on the low or high pin bank
	assign hi_half = (req.addr == ADDR_SET1) || (req.addr == ADDR_CLR1)
		|| (req.addr == ADDR_PUDCLK1);
	assign wide = hi_half ? {req.data, 32'b0} : {32'b0, req.data};
	assign pins = wide[NUM_PINS-1:0];
	assign fidx = req.addr[2:0];

	// Decode and next state
	always_comb begin
		fsel_nxt     = fsel_q;
		drive_nxt    = drive_q;
		up_nxt       = up_q;
		down_nxt     = down_q;
		pcode_nxt    = pcode_q;
		rsp.rdata    = 32'b0;
		rsp.unmapped = 1'b0;
		priority if (req.addr <= ADDR_FSEL_LAST) begin
			if (req.wr == REQ_WRITE) begin
				fsel_nxt[fidx] = req.data[FSEL_BITS-1:0] & FSEL_MASK[fidx];
			end else begin
				rsp.rdata = {2'b0, fsel_q[fidx] & FSEL_MASK[fidx]};
			end
		end else if (req.addr == ADDR_SET0 || req.addr == ADDR_SET1) begin
			if (req.wr == REQ_WRITE) drive_nxt = drive_q | pins;
		end else if (req.addr == ADDR_CLR0 || req.addr == ADDR_CLR1) begin
			if (req.wr == REQ_WRITE) drive_nxt = drive_q & ~pins;
		end else if (req.addr == ADDR_PUD) begin
			if (req.wr == REQ_WRITE) begin
				pcode_nxt = pull_code_t'(req.data[1:0]);
			end else begin
				rsp.rdata = {30'b0, pcode_q};
			end
		end else if (req.addr == ADDR_PUDCLK0 || req.addr == ADDR_PUDCLK1) begin
			// reserved code leaves every pin as it is
			if (req.wr == REQ_WRITE && pcode_q != PULL_RSVD) begin
				for (int p = 0; p < NUM_PINS; p++) begin
					if (pins[p]) begin
						up_nxt[p]   = (pcode_q == PULL_UP);
						down_nxt[p] = (pcode_q == PULL_DOWN);
					end
				end
			end
		end else begin
			rsp.unmapped = 1'b1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsel_q  <= '0;
			drive_q <= '0;
			up_q    <= '0;
			down_q  <= '0;
			pcode_q <= PULL_OFF;
		end else if (acc_en) begin
			fsel_q  <= fsel_nxt;
			drive_q <= drive_nxt;
			up_q    <= up_nxt;
			down_q  <= down_nxt;
			pcode_q <= pcode_nxt;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/gpio_function_select_set_clear_pull.sv @@
// Usage
// Register block of a GPIO controller for NUM_PINS pins, driven by one bus
// access per input item: req_type (read or write), reg_address, write_data.
// Both channels use valid/stall; an item moves on an edge with valid high and
// stall low. Every access gives exactly one result item: read_data, the
// unmapped flag and the pin latch and pull state as they stand after it.
// Each access passes the input register, then the result register.
// Throughput: one access per cycle without result stall; the input register
// feeds the state update and result register, so that path sets the rate.
// A stalled result holds the result register, and the input register takes
// one more item behind it before in_stall rises.
// Reset (arst_n low) clears all function selects (every pin input), the
// output latch, the pull code and every pin pull, and empties both stages.
`default_nettype none

// ----------------------------------------------------------------------------
// gpio_function_select_set_clear_pull
// Top level: input register, access handshake and result register.
// ----------------------------------------------------------------------------
module gpio_function_select_set_clear_pull #(
	parameter int unsigned NUM_PINS = 54
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 req_type,
	input  wire logic [5:0]           reg_address,
	input  wire logic [31:0]          write_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [31:0]               read_data,
	output logic                      unmapped,
	output logic [NUM_PINS-1:0]       pin_drive,
	output logic [NUM_PINS-1:0]       pull_up_pins,
	output logic [NUM_PINS-1:0]       pull_down_pins
);
	import gpio_fscp_pkg::*;

	logic                s1_valid_q;
	req_t                req_s1;
	logic                out_valid_q;
	rsp_t                rsp_s2;
	logic [NUM_PINS-1:0] drive_s2;
	logic [NUM_PINS-1:0] up_s2;
	logic [NUM_PINS-1:0] down_s2;

	logic                adv;
	logic                acc_en;
	rsp_t                rsp;
	logic [NUM_PINS-1:0] drive_nxt;
	logic [NUM_PINS-1:0] up_nxt;
	logic [NUM_PINS-1:0] down_nxt;

	// Flow control: result register frees when empty or taken
	assign adv      = !out_valid_q || !out_stall;
	assign acc_en   = s1_valid_q && adv;
	assign in_stall = s1_valid_q && !adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.wr   <= req_type;
			req_s1.addr <= reg_address;
			req_s1.data <= write_data;
		end
	end

	gpio_fscp_regs #(
		.NUM_PINS (NUM_PINS)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_en    (acc_en),
		.req       (req_s1),
		.rsp       (rsp),
		.drive_nxt (drive_nxt),
		.up_nxt    (up_nxt),
		.down_nxt  (down_nxt)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			rsp_s2   <= rsp;
			drive_s2 <= drive_nxt;
			up_s2    <= up_nxt;
			down_s2  <= down_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = rsp_s2.rdata;
	assign unmapped       = rsp_s2.unmapped;
	assign pin_drive      = drive_s2;
	assign pull_up_pins   = up_s2;
	assign pull_down_pins = down_s2;

endmodule

`default_nettype wire

@@ hw/rtl/gpio_fscp_checker.sv @@
// ----------------------------------------------------------------------------
// gpio_fscp_checker
// Port-level checks on the GPIO controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gpio_function_select_set_clear_pull_defines.svh"

module gpio_fscp_checker #(
	parameter int unsigned NUM_PINS = 54
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                req_type,
	input wire logic [5:0]          reg_address,
	input wire logic [31:0]         write_data,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [31:0]         read_data,
	input wire logic                unmapped,
	input wire logic [NUM_PINS-1:0] pin_drive,
	input wire logic [NUM_PINS-1:0] pull_up_pins,
	input wire logic [NUM_PINS-1:0] pull_down_pins
);
	logic stalled;
	logic in_held;

	assign stalled = out_valid && out_stall;
	assign in_held = in_valid && in_stall;

	// a stalled input item stays offered and unchanged
	`GFSCP_ASSERT_NXT(a_in_hold, clk, arst_n, in_held,
		in_valid && $stable(req_type) && $stable(reg_address) && $stable(write_data))

	// a stalled result item stays offered
	`GFSCP_ASSERT_NXT(a_out_hold, clk, arst_n, stalled, out_valid)

	// and keeps its pin state
	`GFSCP_ASSERT_NXT(a_pins_hold, clk, arst_n, stalled,
		$stable(pin_drive) && $stable(pull_up_pins) && $stable(pull_down_pins))

	// unmapped accesses return no data
	`GFSCP_ASSERT_IMP(a_unmapped_zero, clk, arst_n, out_valid && unmapped,
		read_data == 32'b0)

	// a pin is never pulled both ways
	`GFSCP_ASSERT_IMP(a_pull_excl, clk, arst_n, out_valid,
		(pull_up_pins & pull_down_pins) == '0)

endmodule

bind gpio_function_select_set_clear_pull gpio_fscp_checker #(
	.NUM_PINS (NUM_PINS)
) u_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIO controller register block testbench
// Drives bus reads and writes through the valid/stall request channel, keeps
// a shadow copy of the function selects, output latch and pull state, and
// checks every response item field by field while both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import gpio_fscp_pkg::*;

	localparam int unsigned NUM_PINS    = 54;
	localparam int unsigned ITEM_TARGET = 950;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_WAIT  = 8;

	// Addresses the package does not name
	localparam logic [5:0] ADDR_FSEL0    = 6'd0;
	localparam logic [5:0] ADDR_HOLE_LO  = 6'd6;
	localparam logic [5:0] ADDR_HOLE_MID = 6'd9;
	localparam logic [5:0] ADDR_TOP      = 6'd63;

	// One response item as the block presents it
	typedef struct {
		logic [31:0]         rdata;
		logic                unm;
		logic [NUM_PINS-1:0] drive;
		logic [NUM_PINS-1:0] up;
		logic [NUM_PINS-1:0] down;
	} access_rsp_t;

	// Shadow register file and queue of responses still owed by the block
	class gpio_shadow_regs;
		logic [29:0]         fsel[FSEL_REGS];
		logic [NUM_PINS-1:0] latch;
		pull_code_t          pull_sel;
		pull_code_t          pin_pull[NUM_PINS];
		access_rsp_t         owed[$];
		int unsigned         errors;

		function new();
			foreach (fsel[i]) fsel[i] = '0;
			foreach (pin_pull[i]) pin_pull[i] = PULL_OFF;
			latch    = '0;
			pull_sel = PULL_OFF;
			errors   = 0;
		endfunction

		// Bits of a select register that belong to existing pins
		function logic [29:0] fsel_mask(logic [5:0] r);
			int n;
			logic [63:0] m;
			n = int'(NUM_PINS) - int'(r) * int'(PINS_PER_FSEL);
			if (n <= 0)
				return '0;
			if (n > int'(PINS_PER_FSEL))
				n = int'(PINS_PER_FSEL);
			m = (64'd1 << (3 * n)) - 64'd1;
			return m[29:0];
		endfunction

		// A 32-bit write mapped onto the low or high pin bank
		function logic [NUM_PINS-1:0] to_pins(logic [31:0] data, bit high);
			logic [63:0] v;
			v = {32'b0, data};
			if (high)
				v = v << 32;
			return v[NUM_PINS-1:0];
		endfunction

		function int unsigned pending();
			return owed.size();
		endfunction

		// Update the shadow state for one accepted access and queue its response
		function void note_access(logic wr, logic [5:0] addr, logic [31:0] data);
			access_rsp_t e;
			logic [NUM_PINS-1:0] pins;
			e.rdata = '0;
			e.unm   = 1'b0;
			if (addr <= ADDR_FSEL_LAST) begin
				if (wr == REQ_WRITE)
					fsel[addr] = data[29:0] & fsel_mask(addr);
				else
					e.rdata = {2'b0, fsel[addr] & fsel_mask(addr)};
			end else if (addr == ADDR_SET0 || addr == ADDR_SET1) begin
				if (wr == REQ_WRITE)
					latch = latch | to_pins(data, addr == ADDR_SET1);
			end else if (addr == ADDR_CLR0 || addr == ADDR_CLR1) begin
				if (wr == REQ_WRITE)
					latch = latch & ~to_pins(data, addr == ADDR_CLR1);
			end else if (addr == ADDR_PUD) begin
				if (wr == REQ_WRITE)
					pull_sel = pull_code_t'(data[1:0]);
				else
					e.rdata = {30'b0, pull_sel};
			end else if (addr == ADDR_PUDCLK0 || addr == ADDR_PUDCLK1) begin
				// reserved code leaves every pin as it is
				if (wr == REQ_WRITE && pull_sel != PULL_RSVD) begin
					pins = to_pins(data, addr == ADDR_PUDCLK1);
					for (int p = 0; p < NUM_PINS; p++)
						if (pins[p])
							pin_pull[p] = pull_sel;
				end
			end else begin
				e.unm = 1'b1;
			end
			e.drive = latch;
			for (int p = 0; p < NUM_PINS; p++) begin
				e.up[p]   = (pin_pull[p] == PULL_UP);
				e.down[p] = (pin_pull[p] == PULL_DOWN);
			end
			owed.push_back(e);
		endfunction

		function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 10)
					$display("%t mismatch on %s: expected %h, got %h", $realtime, name,
						want, got);
			end
		endfunction

		// Compare one response item with the oldest one owed
		function void check_rsp(logic [31:0] rd, logic unm, logic [NUM_PINS-1:0] drv,
				logic [NUM_PINS-1:0] up, logic [NUM_PINS-1:0] dn);
			access_rsp_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%t response item with no access outstanding", $realtime);
				return;
			end
			e = owed.pop_front();
			cmp_field("read_data", 64'(e.rdata), 64'(rd));
			cmp_field("unmapped", 64'(e.unm), 64'(unm));
			cmp_field("pin_drive", 64'(e.drive), 64'(drv));
			cmp_field("pull_up_pins", 64'(e.up), 64'(up));
			cmp_field("pull_down_pins", 64'(e.down), 64'(dn));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic                req_type;
	logic [5:0]          reg_address;
	logic [31:0]         write_data;
	logic                out_valid;
	logic                out_stall;
	logic [31:0]         read_data;
	logic                unmapped;
	logic [NUM_PINS-1:0] pin_drive;
	logic [NUM_PINS-1:0] pull_up_pins;
	logic [NUM_PINS-1:0] pull_down_pins;

	gpio_shadow_regs shadow = new();
	int unsigned     items_sent = 0;
	int unsigned     cycle_count = 0;
	bit              calm = 1'b0;

	gpio_function_select_set_clear_pull #(
		.NUM_PINS(NUM_PINS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.reg_address(reg_address),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.unmapped(unmapped),
		.pin_drive(pin_drive),
		.pull_up_pins(pull_up_pins),
		.pull_down_pins(pull_down_pins)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watch both channels on the edge; values are those from before the edge
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && !out_stall)
				shadow.check_rsp(read_data, unmapped, pin_drive, pull_up_pins,
					pull_down_pins);
			if (in_valid && !in_stall)
				shadow.note_access(req_type, reg_address, write_data);
		end
	end

	// Hard stop
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("FAIL");
		$finish;
	end

	// Response back-pressure: free stretches, light and heavy stall, long holds
	initial begin
		int unsigned burst;
		int unsigned mode;
		out_stall <= 1'b0;
		forever begin
			burst = $urandom_range(1, 40);
			mode  = $urandom_range(0, 9);
			repeat (burst) begin
				@(posedge clk);
				case (mode)
					0, 1, 2, 3: out_stall <= 1'b0;
					4, 5, 6, 7: out_stall <= ($urandom_range(0, 3) == 0);
					8:          out_stall <= 1'($urandom_range(0, 1));
					default:    out_stall <= 1'b1;
				endcase
			end
		end
	end

	// Idle cycles before the next item: mostly none or short, a few long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Present one access and hold it until it is taken
	task automatic send_access(input logic wr, input logic [5:0] addr,
			input logic [31:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= wr;
		reg_address <= addr;
		write_data  <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2:       return 32'd1 << $urandom_range(0, 31);
			3:       return ~(32'd1 << $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	// Pull programming: code, one or two PUDCLK writes, maybe a read-back
	task automatic pull_sequence();
		logic [31:0] code_word;
		int unsigned clocks;
		code_word = $urandom();
		code_word[1:0] = 2'($urandom_range(0, 3));
		send_access(REQ_WRITE, ADDR_PUD, code_word);
		clocks = $urandom_range(1, 2);
		repeat (clocks)
			send_access(REQ_WRITE, $urandom_range(0, 1) ? ADDR_PUDCLK1 : ADDR_PUDCLK0,
				rand_word());
		if ($urandom_range(0, 2) == 0)
			send_access(REQ_READ, ADDR_PUD, $urandom());
	endtask

	// One random access or short sequence
	task automatic random_access();
		logic [5:0] drive_regs[4];
		logic [5:0] wo_regs[6];
		int unsigned r;
		drive_regs = '{ADDR_SET0, ADDR_SET1, ADDR_CLR0, ADDR_CLR1};
		wo_regs = '{ADDR_SET0, ADDR_SET1, ADDR_CLR0, ADDR_CLR1, ADDR_PUDCLK0, ADDR_PUDCLK1};
		r = $urandom_range(0, 99);
		if (r < 22)
			send_access(1'($urandom_range(0, 1)), 6'($urandom_range(0, FSEL_REGS - 1)),
				rand_word());
		else if (r < 40)
			send_access(REQ_WRITE, drive_regs[2'($urandom_range(0, 3))], rand_word());
		else if (r < 62)
			pull_sequence();
		else if (r < 72)
			send_access(REQ_READ, wo_regs[3'($urandom_range(0, 5))], $urandom());
		else
			send_access(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)), rand_word());
	endtask

	// Main sequence
	initial begin
		int unsigned stretch_left;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		req_type    <= REQ_READ;
		reg_address <= '0;
		write_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset values, field extremes, ignored bits, pull codes, holes
		send_access(REQ_READ, ADDR_FSEL0, '0);
		send_access(REQ_WRITE, ADDR_FSEL0, '1);
		send_access(REQ_READ, ADDR_FSEL0, '1);
		send_access(REQ_WRITE, ADDR_FSEL_LAST, '1);
		send_access(REQ_READ, ADDR_FSEL_LAST, '0);
		send_access(REQ_WRITE, ADDR_SET0, '1);
		send_access(REQ_WRITE, ADDR_SET1, '1);
		send_access(REQ_READ, ADDR_SET0, '1);
		send_access(REQ_WRITE, ADDR_CLR0, 32'h5555_5555);
		send_access(REQ_WRITE, ADDR_CLR1, '1);
		send_access(REQ_WRITE, ADDR_PUD, {30'h3FFF_FFFF, PULL_UP});
		send_access(REQ_READ, ADDR_PUD, '0);
		send_access(REQ_WRITE, ADDR_PUDCLK0, '1);
		send_access(REQ_WRITE, ADDR_PUD, {30'h0, PULL_DOWN});
		send_access(REQ_WRITE, ADDR_PUDCLK1, '1);
		send_access(REQ_WRITE, ADDR_PUD, {30'h0, PULL_RSVD});
		send_access(REQ_WRITE, ADDR_PUDCLK0, '1);
		send_access(REQ_READ, ADDR_PUD, '0);
		send_access(REQ_WRITE, ADDR_PUD, {30'h0, PULL_OFF});
		send_access(REQ_WRITE, ADDR_PUDCLK0, 32'h0000_FFFF);
		send_access(REQ_READ, ADDR_PUDCLK1, '1);
		send_access(REQ_WRITE, ADDR_HOLE_LO, '1);
		send_access(REQ_READ, ADDR_HOLE_MID, '0);
		send_access(REQ_WRITE, ADDR_TOP, '1);
		send_access(REQ_READ, ADDR_TOP, '0);

		// Random part, with occasional stretches of back-to-back items
		stretch_left = 0;
		while (items_sent < ITEM_TARGET) begin
			if (stretch_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				stretch_left = $urandom_range(20, 80);
			end
			stretch_left--;
			random_access();
		end
		in_valid <= 1'b0;

		// Drain outstanding responses, then watch for strays
		while (shadow.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (shadow.errors == 0 && shadow.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
